// File: rtl/core/rcd_pkg.sv
// ----------------------------------------------------------------------------
// rcd_pkg
// Shared types and constants for the random contention delay block.
// ----------------------------------------------------------------------------
package rcd_pkg;

   localparam int LEN_W    = 32;
   localparam int HOP_W    = 8;
   localparam int LEVEL_W  = 2;
   localparam int DELAY_W  = 50;
   localparam int GEN_W    = 64;
   localparam int CFG_W    = 16;
   localparam int PROD_W   = LEN_W + CFG_W;
   localparam int HPROD_W  = HOP_W + CFG_W;
   localparam int INDEX_W  = 8;
   localparam int DATA_W   = 64;
   localparam int COUNT_W  = 6;

   localparam logic [GEN_W-1:0] SEED_RESET        = 64'd88172645463325252;
   localparam logic [CFG_W-1:0] RANGE_RESET       = 16'd100;
   localparam logic [CFG_W-1:0] CUTOFF_LOW_RESET  = 16'd60;
   localparam logic [CFG_W-1:0] CUTOFF_HIGH_RESET = 16'd90;
   localparam logic [CFG_W-1:0] TICKS_RESET       = 16'd1;

   localparam int SHIFT_A = 13;
   localparam int SHIFT_B = 7;
   localparam int SHIFT_C = 17;

   localparam logic [INDEX_W-1:0] REG_SEED        = 8'd0;
   localparam logic [INDEX_W-1:0] REG_DRAW_RANGE  = 8'd1;
   localparam logic [INDEX_W-1:0] REG_CUTOFF_LOW  = 8'd2;
   localparam logic [INDEX_W-1:0] REG_CUTOFF_HIGH = 8'd3;
   localparam logic [INDEX_W-1:0] REG_TICKS_BYTE  = 8'd4;
   localparam logic [INDEX_W-1:0] REG_TICKS_HOP   = 8'd5;

   localparam logic [LEVEL_W-1:0] LEVEL_NONE = 2'd0;
   localparam logic [LEVEL_W-1:0] LEVEL_LOW  = 2'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_HIGH = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DRAW,
      ST_DIV,
      ST_LEVEL,
      ST_DONE
   } rcd_state_type;

   typedef struct packed {
      logic take;
      logic draw;
      logic level_load;
      logic out_load;
   } rcd_cmd_type;

   typedef struct packed {
      logic div_done;
      logic range_zero;
      logic out_free;
   } rcd_status_type;

   function automatic logic [GEN_W-1:0] xorshift(input logic [GEN_W-1:0] x);
      logic [GEN_W-1:0] a;
      logic [GEN_W-1:0] b;
      a = x ^ (x << SHIFT_A);
      b = a ^ (a >> SHIFT_B);
      return b ^ (b << SHIFT_C);
   endfunction

endpackage

// File: rtl/core/rcd_req_if.sv
// ----------------------------------------------------------------------------
// rcd_req_if
// Request channel: message length and hop count.
// ----------------------------------------------------------------------------
interface rcd_req_if;
   import rcd_pkg::*;
   logic               valid;
   logic               ready;
   logic [LEN_W-1:0]   byte_length;
   logic [HOP_W-1:0]   hop_count;

   modport source (output valid, byte_length, hop_count, input ready);
   modport sink   (input valid, byte_length, hop_count, output ready);
endinterface

// File: rtl/core/rcd_rsp_if.sv
// ----------------------------------------------------------------------------
// rcd_rsp_if
// Response channel: contention level and delay.
// ----------------------------------------------------------------------------
interface rcd_rsp_if;
   import rcd_pkg::*;
   logic                valid;
   logic                ready;
   logic [LEVEL_W-1:0]  contention_level;
   logic [DELAY_W-1:0]  delay_ticks;

   modport source (output valid, contention_level, delay_ticks, input ready);
   modport sink   (input valid, contention_level, delay_ticks, output ready);
endinterface

// File: rtl/core/rcd_csr_if.sv
// ----------------------------------------------------------------------------
// rcd_csr_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface rcd_csr_if;
   import rcd_pkg::*;
   logic                valid;
   logic                ready;
   logic [INDEX_W-1:0]  index;
   logic [DATA_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/rcd_mod.sv
// ----------------------------------------------------------------------------
// rcd_mod
// Iterative 64-bit by 16-bit remainder, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module rcd_mod
   import rcd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [GEN_W-1:0]   dividend,
   input  logic [CFG_W-1:0]   divisor,
   output logic               done,
   output logic [CFG_W-1:0]   remainder
);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic [GEN_W-1:0]   shreg_ff, shreg_in;
   logic [CFG_W-1:0]   div_ff, div_in;
   logic [CFG_W-1:0]   rem_ff, rem_in;
   logic [CFG_W:0]     trial;
   logic [CFG_W:0]     diff;

   assign trial = {rem_ff, shreg_ff[GEN_W-1]};
   assign diff  = trial - {1'b0, div_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      shreg_in = shreg_ff;
      div_in   = div_ff;
      rem_in   = rem_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         shreg_in = dividend;
         div_in   = divisor;
         rem_in   = '0;
      end else if (busy_ff) begin
         shreg_in = shreg_ff << 1;
         cnt_in   = cnt_ff + 1'b1;
         rem_in   = (trial >= {1'b0, div_ff}) ? diff[CFG_W-1:0] : trial[CFG_W-1:0];
         if (cnt_ff == '1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      shreg_ff <= shreg_in;
      div_ff   <= div_in;
      rem_ff   <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// File: rtl/core/rcd_ctrl.sv
// ----------------------------------------------------------------------------
// rcd_ctrl
// Sequencer: accept, draw, reduce, level select, result hand-off.
// ----------------------------------------------------------------------------
module rcd_ctrl
   import rcd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  rcd_status_type  status,
   output rcd_cmd_type     cmd
);

   rcd_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DRAW;
         end
         ST_DRAW: begin
            state_in = status.range_zero ? ST_LEVEL : ST_DIV;
         end
         ST_DIV: begin
            if (status.div_done) state_in = ST_LEVEL;
         end
         ST_LEVEL: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.take  = req_valid;
         end
         ST_DRAW: begin
            cmd.draw = 1'b1;
         end
         ST_LEVEL: begin
            cmd.level_load = 1'b1;
         end
         ST_DONE: begin
            cmd.out_load = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/core/rcd_dp.sv
// ----------------------------------------------------------------------------
// rcd_dp
// Datapath: registers, generator, remainder unit, level and delay math.
// ----------------------------------------------------------------------------
module rcd_dp
   import rcd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  rcd_cmd_type         cmd,
   output rcd_status_type      status,
   input  logic [LEN_W-1:0]    byte_length,
   input  logic [HOP_W-1:0]    hop_count,
   input  logic                csr_write,
   input  logic [INDEX_W-1:0]  csr_index,
   input  logic [DATA_W-1:0]   csr_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [LEVEL_W-1:0]  contention_level,
   output logic [DELAY_W-1:0]  delay_ticks
);

   logic [GEN_W-1:0]   gen_ff;
   logic [CFG_W-1:0]   range_ff, cut_low_ff, cut_high_ff, tpb_ff, tph_ff;
   logic [LEN_W-1:0]   len_ff;
   logic [HOP_W-1:0]   hops_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic [HPROD_W-1:0] hprod_ff;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic               out_valid_ff;
   logic [LEVEL_W-1:0] out_level_ff;
   logic [DELAY_W-1:0] out_delay_ff, delay_in;
   logic [DELAY_W-1:0] scaled;
   logic [GEN_W-1:0]   draw;
   logic               div_done;
   logic [CFG_W-1:0]   rem;

   rcd_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.draw && !status.range_zero),
      .dividend  (gen_ff),
      .divisor   (range_ff),
      .done      (div_done),
      .remainder (rem)
   );

   // generator and register file
   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff      <= SEED_RESET;
         range_ff    <= RANGE_RESET;
         cut_low_ff  <= CUTOFF_LOW_RESET;
         cut_high_ff <= CUTOFF_HIGH_RESET;
         tpb_ff      <= TICKS_RESET;
         tph_ff      <= TICKS_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_SEED:        gen_ff      <= csr_data;
            REG_DRAW_RANGE:  range_ff    <= csr_data[CFG_W-1:0];
            REG_CUTOFF_LOW:  cut_low_ff  <= csr_data[CFG_W-1:0];
            REG_CUTOFF_HIGH: cut_high_ff <= csr_data[CFG_W-1:0];
            REG_TICKS_BYTE:  tpb_ff      <= csr_data[CFG_W-1:0];
            REG_TICKS_HOP:   tph_ff      <= csr_data[CFG_W-1:0];
            default: ;
         endcase
      end else if (cmd.take) begin
         gen_ff <= xorshift(gen_ff);
      end
   end

   assign draw = (range_ff == '0) ? gen_ff : {{(GEN_W-CFG_W){1'b0}}, rem};

   always_comb begin
      if (draw > {{(GEN_W-CFG_W){1'b0}}, cut_high_ff}) begin
         level_in = LEVEL_HIGH;
      end else if (draw > {{(GEN_W-CFG_W){1'b0}}, cut_low_ff}) begin
         level_in = LEVEL_LOW;
      end else begin
         level_in = LEVEL_NONE;
      end
   end

   always_comb begin
      case (level_ff)
         LEVEL_NONE: scaled = DELAY_W'(prod_ff);
         LEVEL_LOW:  scaled = DELAY_W'(prod_ff) << 1;
         LEVEL_HIGH: scaled = (DELAY_W'(prod_ff) << 1) + DELAY_W'(prod_ff);
         default:    scaled = '0;
      endcase
      delay_in = scaled + DELAY_W'(hprod_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         len_ff  <= byte_length;
         hops_ff <= hop_count;
      end
      if (cmd.draw) begin
         prod_ff  <= len_ff * tpb_ff;
         hprod_ff <= hops_ff * tph_ff;
      end
      if (cmd.level_load) begin
         level_ff <= level_in;
      end
      if (cmd.out_load) begin
         out_level_ff <= level_ff;
         out_delay_ff <= delay_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign status.div_done   = div_done;
   assign status.range_zero = (range_ff == '0);
   assign status.out_free   = !out_valid_ff || rsp_ready;

   assign rsp_valid        = out_valid_ff;
   assign contention_level = out_level_ff;
   assign delay_ticks      = out_delay_ff;

endmodule

// File: rtl/core/random_contention_delay.sv
// ----------------------------------------------------------------------------
// random_contention_delay
// Draws a contention level per message and returns its transfer delay.
//
// Channels: req carries byte_length and hop_count, rsp returns
// contention_level and delay_ticks, csr writes the six registers
// (0 seed, 1 draw_range, 2 cutoff_low, 3 cutoff_high, 4 ticks_per_byte,
// 5 ticks_per_hop). A seed write also reloads the generator. csr is
// always ready; write it only while no request is in flight.
// Each request beat steps a 64-bit xorshift generator, reduces it modulo
// draw_range and compares it with the cutoffs. A zero draw_range skips
// the reduction.
// The serial remainder unit handles one dividend bit per cycle. One
// request is processed at a time: a new request beat is taken only once
// the previous one has been handed to the output register.
// The response sits in an output register, so the next request is taken
// while a response waits; a stalled receiver holds the block in its final
// step until that register frees up.
// Reset (synchronous) restores register defaults and the default seed.
// ----------------------------------------------------------------------------
module random_contention_delay
   import rcd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   rcd_req_if.sink      req_if,
   rcd_rsp_if.source    rsp_if,
   rcd_csr_if.sink      csr_if
);

   rcd_cmd_type    cmd;
   rcd_status_type status;

   assign csr_if.ready = 1'b1;

   rcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   rcd_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .byte_length      (req_if.byte_length),
      .hop_count        (req_if.hop_count),
      .csr_write        (csr_if.valid),
      .csr_index        (csr_if.index),
      .csr_data         (csr_if.data),
      .rsp_valid        (rsp_if.valid),
      .rsp_ready        (rsp_if.ready),
      .contention_level (rsp_if.contention_level),
      .delay_ticks      (rsp_if.delay_ticks)
   );

endmodule

// File: test/random_contention_delay_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// random_contention_delay_test
// Self-checking bench for the random contention delay block. A local model
// steps its own xorshift generator per request beat, picks the contention
// level and computes the expected delay. Responses are compared in order.
// Directed cases cover field extremes, a zero seed, a zero range, inverted
// cutoffs, full-scale tick values and writes to unused register indexes. A
// long receiver stall fills the block. Random phases reload registers, the seed only in some.
// ----------------------------------------------------------------------------
module random_contention_delay_test;
   import rcd_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_BEATS = 150;
   localparam logic [INDEX_W-1:0] REG_UNUSED_FIRST = 8'd6;
   localparam logic [INDEX_W-1:0] REG_UNUSED_LAST  = 8'hFF;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic [DELAY_W-1:0] delay;
   } transfer_type;

   logic clock;
   logic reset;

   rcd_req_if req_bus();
   rcd_rsp_if rsp_bus();
   rcd_csr_if csr_bus();

   random_contention_delay i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   // local copy of block state and registers
   logic [GEN_W-1:0] gen_state;
   logic [CFG_W-1:0] draw_range_reg;
   logic [CFG_W-1:0] cutoff_low_reg;
   logic [CFG_W-1:0] cutoff_high_reg;
   logic [CFG_W-1:0] ticks_byte_reg;
   logic [CFG_W-1:0] ticks_hop_reg;

   transfer_type expected_transfers[$];
   int        error_count;
   int        cycle_count;
   bit        quiet_run;
   int        rsp_hold_request;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [GEN_W-1:0] step_generator();
      logic [GEN_W-1:0] x;
      x = gen_state;
      x = x ^ (x << 13);
      x = x ^ (x >> 7);
      x = x ^ (x << 17);
      gen_state = x;
      return x;
   endfunction

   function automatic transfer_type predict_transfer(input logic [LEN_W-1:0] len,
                                                     input logic [HOP_W-1:0] hops);
      logic [63:0]  draw;
      logic [63:0]  delay;
      transfer_type result;
      draw = step_generator();
      if (draw_range_reg != '0)
         draw = draw % 64'(draw_range_reg);
      if (draw > 64'(cutoff_high_reg))
         result.level = LEVEL_HIGH;
      else if (draw > 64'(cutoff_low_reg))
         result.level = LEVEL_LOW;
      else
         result.level = LEVEL_NONE;
      delay = 64'(len) * 64'(ticks_byte_reg) * (64'(result.level) + 64'd1)
            + 64'(hops) * 64'(ticks_hop_reg);
      result.delay = delay[DELAY_W-1:0];
      return result;
   endfunction

   function automatic void apply_register(input logic [INDEX_W-1:0] index,
                                          input logic [DATA_W-1:0] data);
      case (index)
         REG_SEED: begin
            gen_state = data;
         end
         REG_DRAW_RANGE:  draw_range_reg  = data[CFG_W-1:0];
         REG_CUTOFF_LOW:  cutoff_low_reg  = data[CFG_W-1:0];
         REG_CUTOFF_HIGH: cutoff_high_reg = data[CFG_W-1:0];
         REG_TICKS_BYTE:  ticks_byte_reg  = data[CFG_W-1:0];
         REG_TICKS_HOP:   ticks_hop_reg   = data[CFG_W-1:0];
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin : check_beats
      transfer_type want;
      if (!reset) begin
         if (csr_bus.valid && csr_bus.ready)
            apply_register(csr_bus.index, csr_bus.data);
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_transfers.size() == 0) begin
               $error("unexpected response beat: contention_level %0d, delay_ticks %0d",
                      rsp_bus.contention_level, rsp_bus.delay_ticks);
               error_count++;
            end else begin
               want = expected_transfers.pop_front();
               if (rsp_bus.contention_level !== want.level) begin
                  $error("contention_level: expected %0d, actual %0d",
                         want.level, rsp_bus.contention_level);
                  error_count++;
               end
               if (rsp_bus.delay_ticks !== want.delay) begin
                  $error("delay_ticks: expected %0d, actual %0d",
                         want.delay, rsp_bus.delay_ticks);
                  error_count++;
               end
            end
         end
         if (req_bus.valid && req_bus.ready)
            expected_transfers.push_back(predict_transfer(req_bus.byte_length,
                                                          req_bus.hop_count));
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // response sink: random stall bursts, long hold on request
   initial begin : rsp_sink
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_request != 0) begin
            hold_left = rsp_hold_request;
            rsp_hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_bus.ready = 1'b0;
            hold_left--;
         end else if (quiet_run) begin
            rsp_bus.ready = 1'b1;
         end else if (stall_left > 0) begin
            rsp_bus.ready = 1'b0;
            stall_left--;
         end else if ($urandom_range(0, 9) == 0) begin
            rsp_bus.ready = 1'b0;
            stall_left = $urandom_range(1, 18) - 1;
         end else begin
            rsp_bus.ready = 1'b1;
         end
      end
   end

   // one request beat; valid stays high on return
   task automatic send_request(input logic [LEN_W-1:0] len, input logic [HOP_W-1:0] hops);
      int gap;
      gap = 0;
      if (!quiet_run && $urandom_range(0, 5) == 0)
         gap = $urandom_range(1, 18);
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.byte_length = len;
      req_bus.hop_count = hops;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_bus.valid = 1'b0;
      while (expected_transfers.size() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_register(input logic [INDEX_W-1:0] index,
                                 input logic [DATA_W-1:0] data);
      csr_bus.valid = 1'b1;
      csr_bus.index = index;
      csr_bus.data = data;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   // upper data bits are noise; the block keeps the low 16
   task automatic write_field(input logic [INDEX_W-1:0] index, input logic [CFG_W-1:0] value);
      write_register(index, {$urandom, 16'($urandom), value});
   endtask

   task automatic test_default_config();
      send_request('0, '0);
      send_request('1, '1);
      send_request('1, '0);
      send_request('0, '1);
      drain_results();
   endtask

   task automatic test_zero_seed();
      write_register(REG_SEED, '0);
      send_request(32'd1000, 8'd3);
      send_request('1, '1);
      drain_results();
      write_register(REG_SEED, SEED_RESET);
   endtask

   task automatic test_zero_range();
      write_field(REG_DRAW_RANGE, '0);
      write_field(REG_CUTOFF_LOW, '0);
      write_field(REG_CUTOFF_HIGH, '1);
      send_request(32'd17, 8'd2);
      send_request(32'h8000_0000, 8'h80);
      send_request(32'd5, 8'd1);
      drain_results();
   endtask

   task automatic test_inverted_cutoffs();
      write_field(REG_DRAW_RANGE, 16'd100);
      write_field(REG_CUTOFF_LOW, 16'd80);
      write_field(REG_CUTOFF_HIGH, 16'd20);
      repeat (4) send_request($urandom, 8'($urandom));
      drain_results();
   endtask

   task automatic test_full_scale_ticks();
      write_field(REG_DRAW_RANGE, '0);
      write_field(REG_CUTOFF_LOW, '0);
      write_field(REG_CUTOFF_HIGH, '0);
      write_field(REG_TICKS_BYTE, '1);
      write_field(REG_TICKS_HOP, '1);
      send_request('1, '1);
      send_request('0, '0);
      drain_results();
      write_field(REG_TICKS_BYTE, '0);
      write_field(REG_TICKS_HOP, '0);
      write_field(REG_DRAW_RANGE, 16'd1);
      send_request('1, '1);
      drain_results();
   endtask

   task automatic test_unused_index();
      write_field(REG_TICKS_BYTE, 16'd3);
      write_field(REG_TICKS_HOP, 16'd7);
      write_field(REG_DRAW_RANGE, '1);
      write_register(REG_UNUSED_FIRST, {$urandom, $urandom});
      write_register(REG_UNUSED_LAST, {$urandom, $urandom});
      send_request(32'd4096, 8'd9);
      drain_results();
   endtask

   task automatic test_output_backpressure();
      write_field(REG_DRAW_RANGE, 16'd100);
      write_field(REG_CUTOFF_LOW, 16'd33);
      write_field(REG_CUTOFF_HIGH, 16'd66);
      rsp_hold_request = 600;
      @(negedge clock);
      repeat (12) send_request($urandom, 8'($urandom));
      drain_results();
   endtask

   task automatic load_random_config();
      logic [CFG_W-1:0] range;
      case ($urandom_range(0, 11))
         0:       write_register(REG_SEED, '0);
         1:       write_register(REG_SEED, '1);
         2, 3, 4: write_register(REG_SEED, {$urandom, $urandom});
         default: ;
      endcase
      case ($urandom_range(0, 9))
         0:       range = '0;
         1:       range = 16'd1;
         2:       range = '1;
         3, 4:    range = 16'($urandom_range(1, 65535));
         default: range = 16'($urandom_range(2, 200));
      endcase
      write_field(REG_DRAW_RANGE, range);
      write_field(REG_CUTOFF_LOW, ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                           : 16'($urandom_range(0, range)));
      write_field(REG_CUTOFF_HIGH, ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                            : 16'($urandom_range(0, range)));
      write_field(REG_TICKS_BYTE, ($urandom_range(0, 5) == 0) ? '1 : 16'($urandom));
      write_field(REG_TICKS_HOP, ($urandom_range(0, 5) == 0) ? '0 : 16'($urandom));
   endtask

   task automatic test_random_traffic();
      logic [LEN_W-1:0] len;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain_results();
         load_random_config();
         quiet_run = (phase == RANDOM_PHASES - 1);
         for (int n = 0; n < PHASE_BEATS; n++) begin
            case ($urandom_range(0, 9))
               0:       len = '0;
               1:       len = '1;
               2, 3:    len = $urandom_range(0, 255);
               default: len = $urandom;
            endcase
            send_request(len, 8'($urandom_range(0, 255)));
         end
      end
      drain_results();
   endtask

   initial begin
      error_count = 0;
      cycle_count = 0;
      quiet_run = 1'b0;
      rsp_hold_request = 0;
      gen_state = SEED_RESET;
      draw_range_reg = RANGE_RESET;
      cutoff_low_reg = CUTOFF_LOW_RESET;
      cutoff_high_reg = CUTOFF_HIGH_RESET;
      ticks_byte_reg = TICKS_RESET;
      ticks_hop_reg = TICKS_RESET;
      req_bus.valid = 1'b0;
      req_bus.byte_length = '0;
      req_bus.hop_count = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.data = '0;
      reset = 1'b1;
      repeat (7) @(negedge clock);
      reset = 1'b0;

      test_default_config();
      test_zero_seed();
      test_zero_range();
      test_inverted_cutoffs();
      test_full_scale_ticks();
      test_unused_index();
      test_output_backpressure();
      test_random_traffic();

      repeat (80) @(posedge clock);
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// File: random_contention_delay.f
rtl/core/rcd_pkg.sv
rtl/core/rcd_req_if.sv
rtl/core/rcd_rsp_if.sv
rtl/core/rcd_csr_if.sv
rtl/core/rcd_mod.sv
rtl/core/rcd_ctrl.sv
rtl/core/rcd_dp.sv
rtl/core/random_contention_delay.sv
test/random_contention_delay_test.sv
